@@ design/atrlc_pkg.sv @@
// ----------------------------------------------------------------------------
// atrlc_pkg
// Shared constants, keyword tables, event codes and types for the AT
// response line classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package atrlc_pkg;

	localparam int MAX_LINE        = 2048;
	localparam int ADDR_HEX_DIGITS = 12;

	localparam int LEN_W   = $clog2(MAX_LINE + 1);
	localparam int HD_W    = $clog2(ADDR_HEX_DIGITS + 1);
	localparam int ADDR_W  = 48;
	localparam int EV_W    = 4;

	localparam int NUM_KW   = 11;
	localparam int KW_MAX   = 16;
	localparam int KW_IDX_W = $clog2(NUM_KW);
	localparam int KW_LEN_W = $clog2(KW_MAX + 1);
	localparam int KW_POS_W = $clog2(KW_MAX);
	localparam int KW_HIGH  = 5;

	localparam int PFX_LEN  = 6;
	localparam int PP_W     = 3;
	localparam logic [PP_W-1:0] PP_DONE = PP_W'(PFX_LEN);
	localparam logic [PP_W-1:0] PP_FAIL = PP_W'(7);

	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;

	localparam logic [EV_W-1:0] EV_MODE1      = 4'd0;
	localparam logic [EV_W-1:0] EV_MODE2      = 4'd1;
	localparam logic [EV_W-1:0] EV_MODE3      = 4'd2;
	localparam logic [EV_W-1:0] EV_RECONNECT  = 4'd3;
	localparam logic [EV_W-1:0] EV_SCAN_START = 4'd4;
	localparam logic [EV_W-1:0] EV_DEVICE     = 4'd5;
	localparam logic [EV_W-1:0] EV_SCAN_DONE  = 4'd6;
	localparam logic [EV_W-1:0] EV_CONNECTING = 4'd7;
	localparam logic [EV_W-1:0] EV_CONNECTED  = 4'd8;
	localparam logic [EV_W-1:0] EV_TIMEOUT    = 4'd9;
	localparam logic [EV_W-1:0] EV_SCO_UP     = 4'd10;
	localparam logic [EV_W-1:0] EV_SCO_DOWN   = 4'd11;
	localparam logic [EV_W-1:0] EV_OTHER      = 4'd12;

	localparam logic [1:0] LINK_IDLE       = 2'd0;
	localparam logic [1:0] LINK_SCANNING   = 2'd1;
	localparam logic [1:0] LINK_CONNECTING = 2'd2;
	localparam logic [1:0] LINK_CONNECTED  = 2'd3;

	typedef logic [KW_MAX-1:0][7:0] kw_text_t;

	// Text is right aligned: first character sits at byte KW_LEN-1.
	localparam kw_text_t KW_TEXT [NUM_KW] = '{
		kw_text_t'("SET MODE 1"),
		kw_text_t'("SET MODE 2"),
		kw_text_t'("SET MODE 3"),
		kw_text_t'("RECONNECT"),
		kw_text_t'("INQUIRING START"),
		kw_text_t'("INQ COMPLETE"),
		kw_text_t'("CONNECTING"),
		kw_text_t'("CONNECT SUCCESS"),
		kw_text_t'("CONNECT TIMEOUT"),
		kw_text_t'("SETUP SCO"),
		kw_text_t'("DISC SCO")
	};

	localparam logic [KW_LEN_W-1:0] KW_LEN [NUM_KW] = '{
		5'd10, 5'd10, 5'd10, 5'd9, 5'd15, 5'd12, 5'd10, 5'd15, 5'd15, 5'd9, 5'd8
	};

	localparam logic [EV_W-1:0] KW_EVENT [NUM_KW] = '{
		EV_MODE1, EV_MODE2, EV_MODE3, EV_RECONNECT, EV_SCAN_START,
		EV_SCAN_DONE, EV_CONNECTING, EV_CONNECTED, EV_TIMEOUT,
		EV_SCO_UP, EV_SCO_DOWN
	};

	localparam logic [7:0] PFX_TEXT [PFX_LEN] = '{
		8'h41, 8'h54, 8'h2B, 8'h42, 8'h54, 8'h3A
	};

	typedef struct packed {
		logic            taken;
		logic [EV_W-1:0] ev;
	} chain_t;

	typedef struct packed {
		logic [EV_W-1:0]   ev;
		logic [1:0]        mode;
		logic [1:0]        link;
		logic [ADDR_W-1:0] addr;
	} result_t;

	// {valid, value} of a hex digit in either case
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
		else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
		else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
		return r;
	endfunction

endpackage

`default_nettype wire

@@ design/atrlc_kw_cell.sv @@
// ----------------------------------------------------------------------------
// atrlc_kw_cell
// One keyword matcher: bit-parallel progress vector and a seen flag, plus a
// link of the priority chain that picks the lowest-indexed keyword seen.
// ----------------------------------------------------------------------------
`default_nettype none

module atrlc_kw_cell import atrlc_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [KW_IDX_W-1:0] kw_idx,
	input  wire logic [7:0]          byte_in,
	input  wire logic                feed,
	input  wire logic                clr,
	input  wire chain_t              chain_in,
	output chain_t                   chain_out
);

	logic [KW_MAX-1:0] prog_q;
	logic              seen_q;
	logic [KW_MAX-1:0] hit;
	logic [KW_MAX-1:0] prog_n;
	logic              seen_n;

	always_comb begin
		kw_text_t          pat;
		logic [KW_LEN_W-1:0] len;
		logic [KW_POS_W-1:0] pos;
		pat = KW_TEXT[kw_idx];
		len = KW_LEN[kw_idx];
		hit = '0;
		for (int i = 0; i < KW_MAX; i++) begin
			if (KW_LEN_W'(i) < len) begin
				pos = KW_POS_W'(len - KW_LEN_W'(i) - KW_LEN_W'(1));
				hit[i] = (pat[pos] == byte_in);
			end
		end
		prog_n = {prog_q[KW_MAX-2:0], 1'b1} & hit;
		pos = KW_POS_W'(len - KW_LEN_W'(1));
		seen_n = seen_q | prog_n[pos];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_q <= '0;
			seen_q <= 1'b0;
		end else if (clr) begin
			prog_q <= '0;
			seen_q <= 1'b0;
		end else if (feed) begin
			prog_q <= prog_n;
			seen_q <= seen_n;
		end
	end

	always_comb begin
		chain_out = chain_in;
		if (!chain_in.taken && seen_q) begin
			chain_out.taken = 1'b1;
			chain_out.ev    = KW_EVENT[kw_idx];
		end
	end

endmodule

`default_nettype wire

@@ design/atrlc_prefix.sv @@
// ----------------------------------------------------------------------------
// atrlc_prefix
// Device line recognizer: skips leading spaces, matches AT+BT: and shifts
// in the hex address digits.
// ----------------------------------------------------------------------------
`default_nettype none

module atrlc_prefix import atrlc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [7:0]        byte_in,
	input  wire logic              feed,
	input  wire logic              clr,
	output logic                   device,
	output logic [ADDR_W-1:0]      address
);

	logic              lead_q;
	logic [PP_W-1:0]   pp_q;
	logic [HD_W-1:0]   hd_q;
	logic [ADDR_W-1:0] addr_q;
	logic [4:0]        hv;

	assign hv      = hex_value(byte_in);
	assign device  = (pp_q == PP_DONE) && (hd_q == HD_W'(ADDR_HEX_DIGITS));
	assign address = addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= 1'b1;
			pp_q   <= '0;
			hd_q   <= '0;
			addr_q <= '0;
		end else if (clr) begin
			lead_q <= 1'b1;
			pp_q   <= '0;
			hd_q   <= '0;
			addr_q <= '0;
		end else if (feed && !(lead_q && byte_in == CH_SPACE)) begin
			lead_q <= 1'b0;
			if (pp_q < PP_DONE) begin
				if (PFX_TEXT[pp_q] == byte_in) pp_q <= pp_q + PP_W'(1);
				else pp_q <= PP_FAIL;
			end else if (pp_q == PP_DONE && hd_q < HD_W'(ADDR_HEX_DIGITS)) begin
				if (!hv[4]) begin
					pp_q <= PP_FAIL;
				end else begin
					addr_q <= {addr_q[ADDR_W-5:0], hv[3:0]};
					hd_q   <= hd_q + HD_W'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ design/at_response_line_classifier.sv @@
// ----------------------------------------------------------------------------
// at_response_line_classifier
// Frames UART response bytes into lines and classifies each line.
// ----------------------------------------------------------------------------
// One byte is taken every cycle unless the input stalls. A row of eleven keyword
// cells follows the line in parallel and a prefix unit decodes device lines; at
// a newline the cells' priority chain picks the event, and the result (event,
// mode, link state, address) is registered into a two-entry output stage.
// The input stalls only when both output entries are full. Blank lines give
// no result; a line is dropped at its byte MAX_LINE+1 and the rest starts a new line.
`default_nettype none

module at_response_line_classifier import atrlc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [7:0]        rx_byte,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [EV_W-1:0]        event_res,
	output logic [1:0]             mode,
	output logic [1:0]             conn_state,
	output logic [ADDR_W-1:0]      device_address
);

	logic              acc;
	logic              is_lf;
	logic              feed;
	logic              clr;
	logic              over;
	logic [LEN_W-1:0]  plen_q;
	logic [LEN_W-1:0]  plen_n;
	logic              content_q;
	logic [1:0]        mode_q;
	logic [1:0]        link_q;
	logic              device;
	logic [ADDR_W-1:0] address;
	chain_t            chain [NUM_KW+1];
	chain_t            mid;
	result_t           res;
	logic              push;
	logic              pop;
	logic              outv_q;
	logic              skidv_q;
	result_t           out_q;
	result_t           skid_q;

	assign acc    = in_valid && !in_stall;
	assign is_lf  = rx_byte == CH_LF;
	assign feed   = acc && !is_lf;
	assign plen_n = plen_q + LEN_W'(1);
	assign over   = plen_n > LEN_W'(MAX_LINE);
	assign clr    = acc && (is_lf || over);
	assign push   = acc && is_lf && content_q;

	assign chain[0] = '{taken: 1'b0, ev: EV_OTHER};

	always_comb begin
		mid = chain[KW_HIGH];
		if (!mid.taken && device) begin
			mid.taken = 1'b1;
			mid.ev    = EV_DEVICE;
		end
	end

	for (genvar g = 0; g < NUM_KW; g++) begin : g_cell
		chain_t cin;
		if (g == KW_HIGH) begin : g_mid
			assign cin = mid;
		end else begin : g_plain
			assign cin = chain[g];
		end
		atrlc_kw_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.kw_idx    (KW_IDX_W'(g)),
			.byte_in   (rx_byte),
			.feed      (feed),
			.clr       (clr),
			.chain_in  (cin),
			.chain_out (chain[g+1])
		);
	end

	atrlc_prefix u_prefix (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (rx_byte),
		.feed    (feed),
		.clr     (clr),
		.device  (device),
		.address (address)
	);

	always_comb begin
		res.ev   = chain[NUM_KW].taken ? chain[NUM_KW].ev : EV_OTHER;
		res.mode = mode_q;
		res.link = link_q;
		res.addr = (res.ev == EV_DEVICE) ? address : '0;
		case (res.ev)
			EV_MODE1, EV_MODE2, EV_MODE3: begin
				res.mode = res.ev[1:0] + 2'd1;
				res.link = LINK_IDLE;
			end
			EV_SCAN_START: res.link = LINK_SCANNING;
			EV_SCAN_DONE, EV_TIMEOUT: res.link = LINK_IDLE;
			EV_CONNECTING: res.link = LINK_CONNECTING;
			EV_CONNECTED: res.link = LINK_CONNECTED;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q    <= '0;
			content_q <= 1'b0;
			mode_q    <= '0;
			link_q    <= LINK_IDLE;
		end else begin
			if (clr) begin
				plen_q    <= '0;
				content_q <= 1'b0;
			end else if (feed) begin
				plen_q <= plen_n;
				if (rx_byte != CH_SPACE && rx_byte != CH_CR) content_q <= 1'b1;
			end
			if (push) begin
				mode_q <= res.mode;
				link_q <= res.link;
			end
		end
	end

	// two-entry output stage
	assign pop      = outv_q && !out_stall;
	assign in_stall = skidv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outv_q  <= 1'b0;
			skidv_q <= 1'b0;
		end else if (pop || !outv_q) begin
			if (skidv_q) begin
				outv_q  <= 1'b1;
				skidv_q <= push;
			end else begin
				outv_q <= push;
			end
		end else if (push) begin
			skidv_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !outv_q) begin
			if (skidv_q) begin
				out_q  <= skid_q;
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign out_valid      = outv_q;
	assign event_res      = out_q.ev;
	assign mode           = out_q.mode;
	assign conn_state     = out_q.link;
	assign device_address = out_q.addr;

endmodule

`default_nettype wire

@@ design/atrlc_checker.sv @@
// ----------------------------------------------------------------------------
// atrlc_checker
// Port-level checks of the line classifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module atrlc_checker import atrlc_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic [EV_W-1:0]   event_res,
	input wire logic [1:0]        mode,
	input wire logic [1:0]        conn_state,
	input wire logic [ADDR_W-1:0] device_address
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_res)
			&& $stable(device_address))
		else $error("stalled transaction changed");

	a_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res != EV_DEVICE |-> device_address == '0)
		else $error("address on non-device transaction");

	a_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == EV_MODE1 || event_res == EV_MODE2
			|| event_res == EV_MODE3)
		|-> mode == event_res[1:0] + 2'd1 && conn_state == LINK_IDLE)
		else $error("mode event without mode change");

	a_link: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EV_CONNECTED |-> conn_state == LINK_CONNECTED)
		else $error("connected event without connected state");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_res <= EV_OTHER)
		else $error("event code out of range");

endmodule

bind at_response_line_classifier atrlc_checker u_atrlc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.event_res      (event_res),
	.mode           (mode),
	.conn_state     (conn_state),
	.device_address (device_address)
);

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: AT response line classifier testbench
// Streams UART response lines (keyword lines, device lines with hex
// addresses, broken prefixes, blank, noisy and overlong lines) into the
// classifier with random gaps and output stalls. A byte-level tracker
// predicts each line result, and every result transaction is checked
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import atrlc_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [7:0]          rx_byte = 8'd0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [EV_W-1:0]     event_res;
	logic [1:0]          mode;
	logic [1:0]          conn_state;
	logic [ADDR_W-1:0]   device_address;

	at_response_line_classifier DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_res(event_res),
		.mode(mode),
		.conn_state(conn_state),
		.device_address(device_address)
	);

	string kw_str [NUM_KW] = '{
		"SET MODE 1", "SET MODE 2", "SET MODE 3", "RECONNECT", "INQUIRING START",
		"INQ COMPLETE", "CONNECTING", "CONNECT SUCCESS", "CONNECT TIMEOUT",
		"SETUP SCO", "DISC SCO"
	};
	logic [EV_W-1:0] kw_ev [NUM_KW] = '{
		EV_MODE1, EV_MODE2, EV_MODE3, EV_RECONNECT, EV_SCAN_START,
		EV_SCAN_DONE, EV_CONNECTING, EV_CONNECTED, EV_TIMEOUT,
		EV_SCO_UP, EV_SCO_DOWN
	};
	string pfx_str = "AT+BT:";

	logic [7:0]   rx_pending_q [$];
	result_t      line_results_q [$];
	int           errors = 0;
	int           gap_left = 0;
	int           hold_left = 0;
	bit           in_quiet = 1'b0;
	bit           out_quiet = 1'b0;

	logic [1:0]        trk_mode;
	logic [1:0]        trk_link;
	int                ln_len;
	logic [15:0]       kw_shift [NUM_KW];
	logic [NUM_KW-1:0] kw_found;
	logic [PP_W-1:0]   pfx_pos;
	int                hex_cnt;
	logic [63:0]       addr_acc;
	bit                ln_lead_blank;
	bit                ln_nonblank;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void start_line();
		ln_len = 0;
		foreach (kw_shift[k]) kw_shift[k] = '0;
		kw_found = '0;
		pfx_pos = '0;
		hex_cnt = 0;
		addr_acc = '0;
		ln_lead_blank = 1'b1;
		ln_nonblank = 1'b0;
	endfunction

	task automatic classify_byte(input logic [7:0] b);
		logic [15:0]       hit;
		logic [EV_W-1:0]   ev;
		logic [ADDR_W-1:0] addr;
		bit                found;
		int                nib;
		int                len;
		result_t           res;
		if (b == CH_LF) begin
			if (ln_nonblank) begin
				ev = EV_OTHER;
				addr = '0;
				found = 1'b0;
				for (int k = 0; k < KW_HIGH; k++)
					if (!found && kw_found[k]) begin
						ev = kw_ev[k];
						found = 1'b1;
					end
				if (!found && pfx_pos == PP_DONE && hex_cnt == ADDR_HEX_DIGITS) begin
					ev = EV_DEVICE;
					addr = addr_acc[ADDR_W-1:0];
					found = 1'b1;
				end
				for (int k = KW_HIGH; k < NUM_KW; k++)
					if (!found && kw_found[k]) begin
						ev = kw_ev[k];
						found = 1'b1;
					end
				case (ev)
					EV_MODE1, EV_MODE2, EV_MODE3: begin
						trk_mode = ev[1:0] + 2'd1;
						trk_link = LINK_IDLE;
					end
					EV_SCAN_START: trk_link = LINK_SCANNING;
					EV_SCAN_DONE, EV_TIMEOUT: trk_link = LINK_IDLE;
					EV_CONNECTING: trk_link = LINK_CONNECTING;
					EV_CONNECTED: trk_link = LINK_CONNECTED;
					default: ;
				endcase
				res.ev = ev;
				res.mode = trk_mode;
				res.link = trk_link;
				res.addr = addr;
				line_results_q.push_back(res);
			end
			start_line();
		end else begin
			ln_len++;
			if (b != CH_SPACE && b != CH_CR) ln_nonblank = 1'b1;
			for (int k = 0; k < NUM_KW; k++) begin
				len = kw_str[k].len();
				hit = '0;
				for (int i = 0; i < len; i++)
					if (kw_str[k][i] == b) hit[i] = 1'b1;
				kw_shift[k] = ((kw_shift[k] << 1) | 16'd1) & hit;
				if (kw_shift[k][len-1]) kw_found[k] = 1'b1;
			end
			if (!(ln_lead_blank && b == CH_SPACE)) begin
				ln_lead_blank = 1'b0;
				if (pfx_pos < PP_DONE) begin
					if (pfx_str[pfx_pos] == b) pfx_pos = pfx_pos + PP_W'(1);
					else pfx_pos = PP_FAIL;
				end else if (pfx_pos == PP_DONE && hex_cnt < ADDR_HEX_DIGITS) begin
					nib = -1;
					if (b >= 8'h30 && b <= 8'h39) nib = int'(b) - 'h30;
					else if (b >= 8'h61 && b <= 8'h66) nib = int'(b) - 'h61 + 10;
					else if (b >= 8'h41 && b <= 8'h46) nib = int'(b) - 'h41 + 10;
					if (nib < 0) begin
						pfx_pos = PP_FAIL;
					end else begin
						addr_acc = (addr_acc << 4) | 64'(nib);
						hex_cnt++;
					end
				end
			end
			if (ln_len > MAX_LINE) start_line();
		end
	endtask

	function automatic int pick_pause(inout bit quiet);
		int r;
		if ($urandom_range(0, 49) == 0) quiet = !quiet;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) rx_pending_q.push_back(s[i]);
	endtask

	task automatic push_line(input string s);
		push_text(s);
		rx_pending_q.push_back(CH_LF);
	endtask

	task automatic push_filler(input int n);
		string pool;
		pool = "xyz#-. 0q";
		repeat (n) rx_pending_q.push_back(pool[$urandom_range(0, pool.len() - 1)]);
	endtask

	task automatic push_hex(input int n);
		int d;
		repeat (n) begin
			d = $urandom_range(0, 15);
			if (d < 10) rx_pending_q.push_back(8'('h30 + d));
			else if ($urandom_range(0, 1) == 1) rx_pending_q.push_back(8'('h41 + d - 10));
			else rx_pending_q.push_back(8'('h61 + d - 10));
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
		end
	endtask

	// driver: hold a stalled transaction, otherwise insert gaps and advance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= 8'd0;
			gap_left = 0;
			trk_mode = 2'd0;
			trk_link = LINK_IDLE;
			start_line();
		end else begin
			if (in_valid && !in_stall) classify_byte(rx_byte);
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (rx_pending_q.size() > 0) begin
					in_valid <= 1'b1;
					rx_byte <= rx_pending_q.pop_front();
					gap_left = pick_pause(in_quiet);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (line_results_q.size() == 0) begin
					errors++;
					$display("%0t: result expected none, actual event_res %0d addr 0x%0h",
						$time, event_res, device_address);
				end else begin
					want = line_results_q.pop_front();
					check_field("event_res", 64'(want.ev), 64'(event_res));
					check_field("mode", 64'(want.mode), 64'(mode));
					check_field("conn_state", 64'(want.link), 64'(conn_state));
					check_field("device_address", 64'(want.addr), 64'(device_address));
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				hold_left = pick_pause(out_quiet);
			end
		end
	end

	initial begin
		int pick;
		int k;
		int cut;
		int pos;
		int lines;
		int rand_start;
		string s;

		push_line("SET MODE 1");
		push_line("xxSET MODE 2yy");
		push_line("SET MODE 3");
		push_line("RECONNECT");
		push_line("INQUIRING START");
		push_line("   AT+BT:0123456789ab");
		push_line("AT+BT:FFFFFFFFFFFF more INQ COMPLETE");
		push_line("AT+BT:000000000000RECONNECT");
		push_line("AT+BT:aBcDeF0123456");
		push_line("INQ COMPLETE");
		push_line("CONNECTING");
		push_line("CONNECT SUCCESS");
		push_line("CONNECT TIMEOUT");
		push_line("SETUP SCO");
		push_line("DISC SCO");
		push_line("CONNECT");
		push_line("RECONNRECONNECT");
		push_line("CONNECTINGSET MODE 3");
		push_line("SET MODE 4");
		push_line("AT+BT:12345678901");
		push_line("AT+BT:12345G789012");
		push_line(" AT+BX:123456789012");
		push_line("");
		push_line("    ");
		rx_pending_q.push_back(CH_CR);
		rx_pending_q.push_back(CH_LF);
		rx_pending_q.push_back(CH_SPACE);
		rx_pending_q.push_back(CH_CR);
		rx_pending_q.push_back(CH_SPACE);
		rx_pending_q.push_back(CH_LF);
		rx_pending_q.push_back(CH_CR);
		push_line("AT+BT:123456789012");
		rx_pending_q.push_back(8'd0);
		rx_pending_q.push_back(8'd255);
		rx_pending_q.push_back(CH_CR);
		rx_pending_q.push_back(CH_LF);
		push_filler(MAX_LINE - 10);
		push_line("CONNECTING");
		push_filler(MAX_LINE);
		push_line("SET MODE 2");
		push_filler(MAX_LINE + 1);
		push_line("");

		lines = 0;
		rand_start = rx_pending_q.size();
		while (rx_pending_q.size() - rand_start < 650 || lines < 60) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				push_filler($urandom_range(0, 4));
				push_text(kw_str[$urandom_range(0, NUM_KW - 1)]);
				if ($urandom_range(0, 4) == 0) push_text(kw_str[$urandom_range(0, NUM_KW - 1)]);
				push_filler($urandom_range(0, 4));
			end else if (pick < 55) begin
				repeat ($urandom_range(0, 3)) rx_pending_q.push_back(CH_SPACE);
				push_text(pfx_str);
				push_hex(ADDR_HEX_DIGITS);
				if ($urandom_range(0, 2) == 0) begin
					push_filler($urandom_range(0, 3));
					if ($urandom_range(0, 1) == 1) push_text(kw_str[$urandom_range(0, NUM_KW - 1)]);
				end
			end else if (pick < 65) begin
				repeat ($urandom_range(0, 3)) rx_pending_q.push_back(CH_SPACE);
				cut = $urandom_range(0, PFX_LEN);
				for (int i = 0; i < cut; i++) rx_pending_q.push_back(pfx_str[i]);
				if (cut < PFX_LEN) begin
					rx_pending_q.push_back(8'('h41 + $urandom_range(0, 25)));
					push_hex(ADDR_HEX_DIGITS);
				end else if ($urandom_range(0, 1) == 1) begin
					push_hex($urandom_range(0, ADDR_HEX_DIGITS - 1));
				end else begin
					pos = $urandom_range(0, ADDR_HEX_DIGITS - 1);
					push_hex(pos);
					rx_pending_q.push_back(8'('h47 + $urandom_range(0, 19)));
					push_hex(ADDR_HEX_DIGITS - pos);
				end
			end else if (pick < 75) begin
				k = $urandom_range(0, NUM_KW - 1);
				s = kw_str[k];
				pos = $urandom_range(0, s.len() - 1);
				cut = $urandom_range(0, 3) == 0 ? pos : s.len();
				for (int i = 0; i < cut; i++)
					if (i == pos) rx_pending_q.push_back(8'('h41 + $urandom_range(0, 25)));
					else rx_pending_q.push_back(s[i]);
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 24)) rx_pending_q.push_back(8'($urandom_range(0, 255)));
			end else if (pick < 95) begin
				repeat ($urandom_range(0, 4))
					rx_pending_q.push_back($urandom_range(0, 1) == 1 ? CH_SPACE : CH_CR);
			end else begin
				push_filler($urandom_range(60, 400));
				push_text(kw_str[$urandom_range(0, NUM_KW - 1)]);
			end
			rx_pending_q.push_back(CH_LF);
			lines++;
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (rx_pending_q.size() != 0 || in_valid || line_results_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

@@ at_response_line_classifier.f @@
design/atrlc_pkg.sv
design/atrlc_kw_cell.sv
design/atrlc_prefix.sv
design/at_response_line_classifier.sv
design/atrlc_checker.sv
tb/tb_top.sv
